FILE: rtl/core/rfl_pkg.sv
// Shared types and constants of the rank fraction labeler.
// Command and result payload structs, operation codes and register indexes.
// No dependencies.
package rfl_pkg;

	localparam int unsigned MAX_PIXELS = 65536;
	localparam int unsigned ADDR_W     = $clog2(MAX_PIXELS);
	localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned INDEX_W    = 16;
	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned FRAC_W     = 17;
	localparam int unsigned FRAC_SHIFT = 16;
	localparam int unsigned PROD_W     = CNT_W + FRAC_W;
	localparam int unsigned THR_W      = PROD_W - FRAC_SHIFT;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(MAX_PIXELS);
	localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(65536);

	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POS_FRACTION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NEG_FRACTION = 1'b1;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [SAMPLE_W-1:0] sample;
		logic [INDEX_W-1:0]  pixel_index;
	} cmd_t;

	typedef struct packed {
		logic is_positive;
		logic is_negative;
		logic index_error;
	} res_t;

endpackage

FILE: rtl/core/rank_fraction_labeler.sv
// Rank fraction labeler top level: sample memory, scan sequencer and shared multiplier.
// Depends on rfl_pkg for payload types, operation codes and register indexes.
// Append and clear complete in the idle state. A query in range passes through fetch,
// two multiplier states, a scan over the loaded samples, drain and done; the scan uses the
// single memory read port, one entry per cycle; an out-of-range query skips to done.
// Results wait in an output register; the block takes no command while a query runs.
// The sample memory needs no clearing pass after reset.
module rank_fraction_labeler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  rfl_pkg::cmd_t                  cmd,
	output logic                           res_valid,
	input  logic                           res_ready,
	output rfl_pkg::res_t                  res,
	input  logic                           cfg_we,
	input  logic [rfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfl_pkg::FRAC_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MULP,
		ST_MULN,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [rfl_pkg::CNT_W-1:0]       count_q;
	logic [rfl_pkg::FRAC_W-1:0]      pos_frac_q;
	logic [rfl_pkg::FRAC_W-1:0]      neg_frac_q;
	logic [rfl_pkg::INDEX_W-1:0]     idx_q;
	logic [rfl_pkg::SAMPLE_W-1:0]    ref_q;
	logic [rfl_pkg::ADDR_W-1:0]      j_q;
	logic [rfl_pkg::CNT_W-1:0]       pos_q;
	logic [rfl_pkg::THR_W-1:0]       pos_thr_q;
	logic [rfl_pkg::THR_W-1:0]       neg_thr_q;
	logic                            err_q;
	logic                            res_valid_q;
	rfl_pkg::res_t                   res_q;
	logic                            cmp_v_s1;
	logic [rfl_pkg::ADDR_W-1:0]      cmp_j_s1;

	logic [rfl_pkg::SAMPLE_W-1:0]    mem [rfl_pkg::MAX_PIXELS];
	logic [rfl_pkg::SAMPLE_W-1:0]    rdata_q;
	logic [rfl_pkg::ADDR_W-1:0]      raddr;
	logic                            mem_we;

	logic                            cmd_xfer;
	logic                            idx_bad;
	logic                            last_j;
	logic                            hit;
	logic                            out_free;
	logic [rfl_pkg::FRAC_W-1:0]      neg_comp;
	logic [rfl_pkg::FRAC_W-1:0]      mul_b;
	logic [rfl_pkg::PROD_W-1:0]      product;
	logic [rfl_pkg::THR_W-1:0]       thr;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_free  = !res_valid_q || res_ready;

	assign idx_bad = {1'b0, cmd.pixel_index} >= count_q;
	assign last_j  = {1'b0, j_q} == (count_q - rfl_pkg::CNT_W'(1));
	assign mem_we  = cmd_xfer && (cmd.func == rfl_pkg::FUNC_APPEND)
	                 && (count_q < rfl_pkg::COUNT_FULL);
	assign raddr   = (state_q == ST_FETCH) ? idx_q : j_q;

	assign hit = (rdata_q > ref_q) || ((rdata_q == ref_q) && (cmp_j_s1 > idx_q));

	// shared multiplier: positive threshold, then negative threshold
	assign neg_comp = (neg_frac_q <= rfl_pkg::FRAC_ONE) ? (rfl_pkg::FRAC_ONE - neg_frac_q)
	                                                    : '0;
	assign mul_b    = (state_q == ST_MULP) ? pos_frac_q : neg_comp;
	assign product  = rfl_pkg::PROD_W'(count_q) * rfl_pkg::PROD_W'(mul_b);
	assign thr      = product[rfl_pkg::PROD_W-1:rfl_pkg::FRAC_SHIFT];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[rfl_pkg::ADDR_W-1:0]] <= cmd.sample;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pos_frac_q  <= '0;
			neg_frac_q  <= '0;
			res_valid_q <= 1'b0;
			cmp_v_s1    <= 1'b0;
			err_q       <= 1'b0;
			pos_q       <= '0;
			j_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rfl_pkg::REG_POS_FRACTION: pos_frac_q <= cfg_data;
					rfl_pkg::REG_NEG_FRACTION: neg_frac_q <= cfg_data;
					default: ;
				endcase
			end

			if (res_valid_q && res_ready && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end

			cmp_v_s1 <= (state_q == ST_SCAN);
			cmp_j_s1 <= j_q;
			if (cmp_v_s1 && hit) begin
				pos_q <= pos_q + rfl_pkg::CNT_W'(1);
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						idx_q <= cmd.pixel_index;
						case (cmd.func)
							rfl_pkg::FUNC_APPEND: begin
								if (count_q < rfl_pkg::COUNT_FULL) begin
									count_q <= count_q + rfl_pkg::CNT_W'(1);
								end
							end
							rfl_pkg::FUNC_CLEAR: begin
								count_q <= '0;
							end
							rfl_pkg::FUNC_QUERY: begin
								err_q   <= idx_bad;
								state_q <= idx_bad ? ST_DONE : ST_FETCH;
							end
							default: ;
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_MULP;
				end
				ST_MULP: begin
					ref_q     <= rdata_q;
					pos_thr_q <= thr;
					j_q       <= '0;
					pos_q     <= '0;
					state_q   <= ST_MULN;
				end
				ST_MULN: begin
					neg_thr_q <= thr;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					j_q <= j_q + rfl_pkg::ADDR_W'(1);
					if (last_j) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						res_valid_q       <= 1'b1;
						res_q.index_error <= err_q;
						res_q.is_positive <= !err_q
						                     && (rfl_pkg::THR_W'(pos_q) <= pos_thr_q);
						res_q.is_negative <= !err_q
						                     && (rfl_pkg::THR_W'(pos_q) >= neg_thr_q);
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rfl_pkg::COUNT_FULL)
		else $error("loaded count beyond capacity");

	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (count_q == $past(count_q)) || (state_q == ST_IDLE))
		else $error("loaded count moved during a query");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && !err_q |-> pos_q < count_q)
		else $error("rank not below loaded count");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.index_error |-> !res_q.is_positive && !res_q.is_negative)
		else $error("error result carries labels");

	a_scan_needs_samples: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> ({1'b0, idx_q} < count_q))
		else $error("scan started for out-of-range pixel");

endmodule
